// ===== rtl/core/ddd_pkg.sv =====
// ----------------------------------------------------------------------------
// ddd_pkg
// Types, constants and calendar helpers shared by the date difference block.
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int unsigned YEAR_MAX_DEF = 9999;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned DNUM_W   = 23;
  localparam int unsigned GAP_W    = 22;
  localparam int unsigned ORDER_W  = 2;
  localparam int unsigned MLEN_W   = 5;
  localparam int unsigned DBM_W    = 9;
  localparam int unsigned QUART_W  = YEAR_W - 2;
  localparam int unsigned QUOT_W   = 8;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned CENT_QUARTERS = 25;
  localparam int unsigned RECIP25       = 1311;
  localparam int unsigned RECIP25_SHIFT = 15;
  localparam int unsigned RECIP_PROD_W  = RECIP25_SHIFT + QUOT_W;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef enum logic [ORDER_W-1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LATER   = 2'd1,
    ORD_EARLIER = 2'd2
  } order_e;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t first;
    date_t second;
  } pair_t;

  typedef struct packed {
    logic              valid;
    logic [DNUM_W-1:0] day_num;
  } date_info_t;

  typedef struct packed {
    logic               first_valid;
    logic               second_valid;
    logic [ORDER_W-1:0] order;
    logic [GAP_W-1:0]   day_gap;
  } result_t;

  function automatic logic [QUOT_W-1:0] div25(input logic [QUART_W-1:0] v);
    logic [RECIP_PROD_W-1:0] prod;
    prod = RECIP_PROD_W'(v) * RECIP_PROD_W'(RECIP25);
    return prod[RECIP25_SHIFT +: QUOT_W];
  endfunction

  function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
    logic [MLEN_W-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? MLEN_W'(29) : MLEN_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = MLEN_W'(30);
      default:                   len = MLEN_W'(31);
    endcase
    return len;
  endfunction

  function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DBM_W-1:0] dbm;
    unique case (month)
      4'd2:    dbm = DBM_W'(31);
      4'd3:    dbm = DBM_W'(59);
      4'd4:    dbm = DBM_W'(90);
      4'd5:    dbm = DBM_W'(120);
      4'd6:    dbm = DBM_W'(151);
      4'd7:    dbm = DBM_W'(181);
      4'd8:    dbm = DBM_W'(212);
      4'd9:    dbm = DBM_W'(243);
      4'd10:   dbm = DBM_W'(273);
      4'd11:   dbm = DBM_W'(304);
      4'd12:   dbm = DBM_W'(334);
      default: dbm = '0;
    endcase
    return dbm;
  endfunction

endpackage

// ===== rtl/core/ddd_if.sv =====
// ----------------------------------------------------------------------------
// ddd_if
// Valid/ready channels for date pairs and difference results.
// ----------------------------------------------------------------------------
interface ddd_in_if;
  logic                         valid;
  logic                         ready;
  logic [ddd_pkg::DAY_W-1:0]    day_first;
  logic [ddd_pkg::MONTH_W-1:0]  month_first;
  logic [ddd_pkg::YEAR_W-1:0]   year_first;
  logic [ddd_pkg::DAY_W-1:0]    day_second;
  logic [ddd_pkg::MONTH_W-1:0]  month_second;
  logic [ddd_pkg::YEAR_W-1:0]   year_second;

  modport source (
    output valid, day_first, month_first, year_first,
           day_second, month_second, year_second,
    input  ready
  );
  modport sink (
    input  valid, day_first, month_first, year_first,
           day_second, month_second, year_second,
    output ready
  );
endinterface

interface ddd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         first_valid;
  logic                         second_valid;
  logic [ddd_pkg::ORDER_W-1:0]  order;
  logic [ddd_pkg::GAP_W-1:0]    day_gap;

  modport source (
    output valid, first_valid, second_valid, order, day_gap,
    input  ready
  );
  modport sink (
    input  valid, first_valid, second_valid, order, day_gap,
    output ready
  );
endinterface

// ===== rtl/core/ddd_date_unit.sv =====
// ----------------------------------------------------------------------------
// ddd_date_unit
// Checks one date and gives its ordinal day number from 0001-01-01.
// ----------------------------------------------------------------------------
module ddd_date_unit #(
  parameter int unsigned YEAR_MAX = ddd_pkg::YEAR_MAX_DEF
) (
  input  ddd_pkg::date_t      date_i,
  output ddd_pkg::date_info_t info_o
);

  logic [ddd_pkg::QUART_W-1:0] y_quart;
  logic [ddd_pkg::QUOT_W-1:0]  y_q25;
  logic                        y_rem_zero;
  logic                        leap;
  logic [ddd_pkg::MLEN_W-1:0]  mlen;
  logic                        year_ok;
  logic                        month_ok;
  logic                        day_ok;
  logic [ddd_pkg::YEAR_W-1:0]  prev_year;
  logic [ddd_pkg::QUART_W-1:0] p_quart;
  logic [ddd_pkg::QUOT_W-1:0]  p_cent;
  logic                        leap_adj;

  // leap: divisible by 4, and not a century unless divisible by 400
  assign y_quart    = date_i.year[ddd_pkg::YEAR_W-1:2];
  assign y_q25      = ddd_pkg::div25(y_quart);
  assign y_rem_zero = (y_quart ==
                       ddd_pkg::QUART_W'(ddd_pkg::QUART_W'(y_q25) *
                                         ddd_pkg::QUART_W'(ddd_pkg::CENT_QUARTERS)));
  assign leap       = (date_i.year[1:0] == 2'd0) && (!y_rem_zero || (y_q25[1:0] == 2'd0));

  assign mlen     = ddd_pkg::month_len(date_i.month, leap);
  assign year_ok  = (date_i.year != '0) && (32'(date_i.year) <= 32'(YEAR_MAX));
  assign month_ok = (date_i.month >= ddd_pkg::MONTH_JAN) && (date_i.month <= ddd_pkg::MONTH_DEC);
  assign day_ok   = (date_i.day != '0) && (date_i.day <= mlen);

  assign prev_year = date_i.year - ddd_pkg::YEAR_W'(1);
  assign p_quart   = prev_year[ddd_pkg::YEAR_W-1:2];
  assign p_cent    = ddd_pkg::div25(p_quart);
  assign leap_adj  = leap && (date_i.month > ddd_pkg::MONTH_FEB);

  assign info_o.valid   = year_ok && month_ok && day_ok;
  assign info_o.day_num =
      ddd_pkg::DNUM_W'(prev_year) * ddd_pkg::DNUM_W'(ddd_pkg::DAYS_PER_YEAR)
    + ddd_pkg::DNUM_W'(p_quart)
    - ddd_pkg::DNUM_W'(p_cent)
    + ddd_pkg::DNUM_W'(p_cent[ddd_pkg::QUOT_W-1:2])
    + ddd_pkg::DNUM_W'(ddd_pkg::days_before(date_i.month))
    + ddd_pkg::DNUM_W'(leap_adj)
    + ddd_pkg::DNUM_W'(date_i.day);

endmodule

// ===== rtl/core/date_day_difference.sv =====
// ----------------------------------------------------------------------------
// date_day_difference
// Gregorian date pair to validity flags, ordering and absolute day gap.
// ----------------------------------------------------------------------------
// Each transfer on in_i carries two dates; one result per pair leaves on
// out_o via the input and result registers. The date pair is registered,
// both dates are checked and turned into day numbers by constant-coefficient
// arithmetic, and the result register drives out_o. A new pair is taken
// every cycle while out_o keeps draining; the result register and the input
// register each hold one item, so up to two pairs are in flight. day_gap is
// zero when either date is invalid; order compares the raw year, month and
// day fields in every case. Years above YEAR_MAX count as invalid.
// ----------------------------------------------------------------------------
module date_day_difference #(
  parameter int unsigned YEAR_MAX = ddd_pkg::YEAR_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ddd_in_if.sink         in_i,
  ddd_out_if.source      out_o
);

  logic                        in_valid_q;
  ddd_pkg::pair_t              in_q;
  logic                        out_valid_q;
  ddd_pkg::result_t            res_q;
  ddd_pkg::result_t            res_d;
  logic                        out_en;
  logic                        in_en;
  ddd_pkg::date_info_t         info_first;
  ddd_pkg::date_info_t         info_second;
  ddd_pkg::order_e             order;
  logic [ddd_pkg::DNUM_W-1:0]  diff;

  assign out_en     = !out_valid_q || out_o.ready;
  assign in_en      = !in_valid_q || out_en;
  assign in_i.ready = in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_en) begin
        in_valid_q <= in_i.valid;
      end
      if (out_en) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && in_i.valid) begin
      in_q.first  <= '{year: in_i.year_first, month: in_i.month_first, day: in_i.day_first};
      in_q.second <= '{year: in_i.year_second, month: in_i.month_second,
                       day: in_i.day_second};
    end
    if (out_en && in_valid_q) begin
      res_q <= res_d;
    end
  end

  ddd_date_unit #(.YEAR_MAX(YEAR_MAX)) u_first (
    .date_i (in_q.first),
    .info_o (info_first)
  );

  ddd_date_unit #(.YEAR_MAX(YEAR_MAX)) u_second (
    .date_i (in_q.second),
    .info_o (info_second)
  );

  always_comb begin
    priority if (in_q.first == in_q.second) begin
      order = ddd_pkg::ORD_EQUAL;
    end else if (in_q.first > in_q.second) begin
      order = ddd_pkg::ORD_LATER;
    end else begin
      order = ddd_pkg::ORD_EARLIER;
    end
  end

  assign diff = (info_first.day_num >= info_second.day_num)
              ? (info_first.day_num - info_second.day_num)
              : (info_second.day_num - info_first.day_num);

  always_comb begin
    res_d.first_valid  = info_first.valid;
    res_d.second_valid = info_second.valid;
    res_d.order        = order;
    res_d.day_gap      = (info_first.valid && info_second.valid)
                       ? diff[ddd_pkg::GAP_W-1:0] : '0;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.first_valid  = res_q.first_valid;
  assign out_o.second_valid = res_q.second_valid;
  assign out_o.order        = res_q.order;
  assign out_o.day_gap      = res_q.day_gap;

endmodule

// ===== rtl/core/ddd_checker.sv =====
// ----------------------------------------------------------------------------
// ddd_checker
// Port-level checks for the date difference block, bound to the top level.
// ----------------------------------------------------------------------------
module ddd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        first_valid_i,
  input logic                        second_valid_i,
  input logic [ddd_pkg::ORDER_W-1:0] order_i,
  input logic [ddd_pkg::GAP_W-1:0]   day_gap_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(first_valid_i) && $stable(second_valid_i) &&
      $stable(order_i) && $stable(day_gap_i))
    else $error("result changed while stalled");

  a_gap_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !(first_valid_i && second_valid_i) |-> day_gap_i == '0)
    else $error("non-zero gap with an invalid date");

  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && day_gap_i != '0 |-> order_i != ddd_pkg::ORD_EQUAL)
    else $error("non-zero gap for equal dates");

  a_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without an input transfer");

endmodule

bind date_day_difference ddd_checker u_ddd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .first_valid_i  (out_o.first_valid),
  .second_valid_i (out_o.second_valid),
  .order_i        (out_o.order),
  .day_gap_i      (out_o.day_gap)
);
